FILE: rtl/smet_pkg.sv
// ----------------------------------------------------------------------------
// smet_pkg
// Shared types and constants of the sparse matrix entry table: table sizing,
// field widths, operation and status codes, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package smet_pkg;

   // table sizing
   localparam int CAPACITY = 64;
   localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   // field widths
   localparam int KIND_W   = 2;
   localparam int INDEX_W  = 16;
   localparam int VALUE_W  = 64;
   localparam int STATUS_W = 2;
   localparam int DIM_W    = 17;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BOUNDS  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_COUNT = 2'd1;

   localparam logic [DIM_W-1:0] DIM_RESET = 17'h10000;

   // one stored record
   typedef struct packed {
      logic [INDEX_W-1:0] row;
      logic [INDEX_W-1:0] column;
      logic [VALUE_W-1:0] value;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

FILE: rtl/sparse_matrix_entry_table_core.sv
// ----------------------------------------------------------------------------
// sparse_matrix_entry_table_core
// Coordinate-list store of up to CAPACITY (row, column, value) records with
// insert/update, remove (last record moves into the hole) and read requests.
// ----------------------------------------------------------------------------
// Flow: a read hit responds from the scan; an update or append passes through
//   the write state; a remove hit reads the last record and moves it into the
//   hole; a bounds failure or kind 3 goes straight to the response state.
// Requests: one at a time; the scan through the single RAM read port checks
//   one record per cycle.
// Reset: synchronous; zeroes the record count and result valid, limits 65536.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_matrix_entry_table_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [smet_pkg::KIND_W-1:0]          req_kind,
   input  wire logic [smet_pkg::INDEX_W-1:0]         req_row_index,
   input  wire logic [smet_pkg::INDEX_W-1:0]         req_column_index,
   input  wire logic [smet_pkg::VALUE_W-1:0]         req_entry_value,
   // result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic      [smet_pkg::STATUS_W-1:0]        rsp_status,
   output logic      [smet_pkg::VALUE_W-1:0]         rsp_read_value,
   output logic      [smet_pkg::COUNT_W-1:0]         rsp_entry_total,
   // configuration write channel
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [smet_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [smet_pkg::DIM_W-1:0]           csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST_RD,
      ST_MOVE,
      ST_WRITE,
      ST_RESPOND
   } state_type;

   state_type state_ff, state_in;

   // control state
   logic [smet_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [smet_pkg::COUNT_W-1:0]  idx_ff, idx_in;
   logic                          chk_valid_ff, chk_valid_in;
   logic [smet_pkg::SLOT_W-1:0]   chk_idx_ff, chk_idx_in;
   logic [smet_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic                          append_ff, append_in;
   logic [smet_pkg::DIM_W-1:0]    row_count_ff, row_count_in;
   logic [smet_pkg::DIM_W-1:0]    column_count_ff, column_count_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // request and result payload
   logic [smet_pkg::KIND_W-1:0]   op_kind_ff, op_kind_in;
   logic [smet_pkg::INDEX_W-1:0]  op_row_ff, op_row_in;
   logic [smet_pkg::INDEX_W-1:0]  op_column_ff, op_column_in;
   logic [smet_pkg::VALUE_W-1:0]  op_value_ff, op_value_in;
   logic [smet_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [smet_pkg::VALUE_W-1:0]  res_value_ff, res_value_in;
   logic [smet_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [smet_pkg::VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [smet_pkg::COUNT_W-1:0]  rsp_total_ff, rsp_total_in;

   // RAM port signals
   logic                          ram_wr_en;
   logic [smet_pkg::SLOT_W-1:0]   ram_wr_addr;
   smet_pkg::entry_type           ram_wr_data;
   logic                          ram_rd_en;
   logic [smet_pkg::SLOT_W-1:0]   ram_rd_addr;
   smet_pkg::entry_type           ram_rd_data;

   logic                          in_bounds;
   logic                          issue;
   logic                          hit;
   logic [smet_pkg::COUNT_W-1:0]  last_slot;
   logic                          rsp_load;

   smet_ram #(
      .WIDTH (smet_pkg::ENTRY_W),
      .DEPTH (smet_pkg::CAPACITY)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall       = (state_ff != ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_entry_total = rsp_total_ff;

   // bounds check on the incoming request
   assign in_bounds = ({1'b0, req_row_index} < row_count_ff) &&
                      ({1'b0, req_column_index} < column_count_ff);

   // scan: issue one read a cycle, compare the data in the next cycle
   assign issue     = (state_ff == ST_SCAN) && (idx_ff < count_ff);
   assign hit       = chk_valid_ff && (ram_rd_data.row == op_row_ff) &&
                      (ram_rd_data.column == op_column_ff);
   assign last_slot = count_ff - smet_pkg::COUNT_W'(1);
   assign rsp_load  = (state_ff == ST_RESPOND) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      idx_in          = idx_ff;
      chk_valid_in    = chk_valid_ff;
      chk_idx_in      = chk_idx_ff;
      slot_in         = slot_ff;
      append_in       = append_ff;
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      rsp_valid_in    = rsp_valid_ff;
      op_kind_in      = op_kind_ff;
      op_row_in       = op_row_ff;
      op_column_in    = op_column_ff;
      op_value_in     = op_value_ff;
      res_status_in   = res_status_ff;
      res_value_in    = res_value_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_total_in    = rsp_total_ff;

      ram_wr_en          = 1'b0;
      ram_wr_addr        = slot_ff;
      ram_wr_data.row    = op_row_ff;
      ram_wr_data.column = op_column_ff;
      ram_wr_data.value  = op_value_ff;
      ram_rd_en          = 1'b0;
      ram_rd_addr        = idx_ff[smet_pkg::SLOT_W-1:0];

      // take configuration writes
      if (csr_valid) begin
         case (csr_index)
            smet_pkg::CSR_ROW_COUNT:    row_count_in    = csr_data;
            smet_pkg::CSR_COLUMN_COUNT: column_count_in = csr_data;
            default: ;
         endcase
      end

      // drop the result once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_kind_in    = req_kind;
               op_row_in     = req_row_index;
               op_column_in  = req_column_index;
               op_value_in   = req_entry_value;
               idx_in        = '0;
               chk_valid_in  = 1'b0;
               append_in     = 1'b0;
               res_status_in = smet_pkg::STATUS_OK;
               res_value_in  = '0;
               if ((req_kind == smet_pkg::KIND_INSERT || req_kind == smet_pkg::KIND_READ)
                   && !in_bounds) begin
                  res_status_in = smet_pkg::STATUS_BOUNDS;
                  state_in      = ST_RESPOND;
               end else if (req_kind == smet_pkg::KIND_INSERT ||
                            req_kind == smet_pkg::KIND_REMOVE ||
                            req_kind == smet_pkg::KIND_READ) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_RESPOND;
               end
            end
         end

         ST_SCAN: begin
            ram_rd_en    = issue;
            chk_valid_in = issue;
            chk_idx_in   = idx_ff[smet_pkg::SLOT_W-1:0];
            if (issue) begin
               idx_in = idx_ff + smet_pkg::COUNT_W'(1);
            end
            if (hit) begin
               // match found: stop the scan
               chk_valid_in = 1'b0;
               slot_in      = chk_idx_ff;
               case (op_kind_ff)
                  smet_pkg::KIND_INSERT: state_in = ST_WRITE;
                  smet_pkg::KIND_REMOVE: state_in = ST_LAST_RD;
                  smet_pkg::KIND_READ: begin
                     res_value_in = ram_rd_data.value;
                     state_in     = ST_RESPOND;
                  end
                  default: state_in = ST_RESPOND;
               endcase
            end else if (!chk_valid_ff && !issue) begin
               // all stored records checked without a match
               case (op_kind_ff)
                  smet_pkg::KIND_INSERT: begin
                     if (count_ff == smet_pkg::COUNT_W'(smet_pkg::CAPACITY)) begin
                        res_status_in = smet_pkg::STATUS_FULL;
                        state_in      = ST_RESPOND;
                     end else begin
                        slot_in   = count_ff[smet_pkg::SLOT_W-1:0];
                        append_in = 1'b1;
                        state_in  = ST_WRITE;
                     end
                  end
                  smet_pkg::KIND_REMOVE: begin
                     res_status_in = smet_pkg::STATUS_MISSING;
                     state_in      = ST_RESPOND;
                  end
                  default: state_in = ST_RESPOND;
               endcase
            end
         end

         ST_LAST_RD: begin
            // fetch the last record to fill the hole
            ram_rd_en   = 1'b1;
            ram_rd_addr = last_slot[smet_pkg::SLOT_W-1:0];
            state_in    = ST_MOVE;
         end

         ST_MOVE: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_rd_data;
            count_in    = last_slot;
            state_in    = ST_RESPOND;
         end

         ST_WRITE: begin
            ram_wr_en = 1'b1;
            if (append_ff) begin
               count_in = count_ff + smet_pkg::COUNT_W'(1);
            end
            state_in = ST_RESPOND;
         end

         ST_RESPOND: begin
            // hold until the result register is free
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_total_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= '0;
         idx_ff          <= '0;
         chk_valid_ff    <= 1'b0;
         append_ff       <= 1'b0;
         row_count_ff    <= smet_pkg::DIM_RESET;
         column_count_ff <= smet_pkg::DIM_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         idx_ff          <= idx_in;
         chk_valid_ff    <= chk_valid_in;
         append_ff       <= append_in;
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      chk_idx_ff    <= chk_idx_in;
      slot_ff       <= slot_in;
      op_kind_ff    <= op_kind_in;
      op_row_ff     <= op_row_in;
      op_column_ff  <= op_column_in;
      op_value_ff   <= op_value_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_total_ff  <= rsp_total_in;
   end

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= smet_pkg::COUNT_W'(smet_pkg::CAPACITY))
      else $error("record count exceeds capacity");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_WRITE || state_ff == ST_MOVE))
      else $error("table written outside a write state");

   a_check_in_scan: assert property (@(posedge clock) disable iff (reset)
      chk_valid_ff |-> (state_ff == ST_SCAN))
      else $error("pending compare outside the scan");

   a_total_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_entry_total == count_ff))
      else $error("result total differs from record count");

endmodule

`default_nettype wire

FILE: rtl/smet_ram.sv
// ----------------------------------------------------------------------------
// smet_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module smet_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sparse matrix entry table core. A clocked
// driver feeds requests from a queue; each accepted request is run through a
// shadow coordinate table that predicts status, read value and entry total.
// A clocked monitor checks every response against the oldest prediction.
// The run walks through several row and column limits and idling modes.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [smet_pkg::KIND_W-1:0]      KIND_UNUSED    = 2'd3;
   localparam logic [smet_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED_A = 2'd2;
   localparam logic [smet_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED_B = 2'd3;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int ITEMS_PER_PHASE = 185;
   localparam int PHASE_COUNT     = 8;

   typedef struct packed {
      logic [smet_pkg::KIND_W-1:0]  kind;
      logic [smet_pkg::INDEX_W-1:0] row;
      logic [smet_pkg::INDEX_W-1:0] column;
      logic [smet_pkg::VALUE_W-1:0] value;
   } table_request_type;

   typedef struct packed {
      logic [smet_pkg::STATUS_W-1:0] status;
      logic [smet_pkg::VALUE_W-1:0]  read_value;
      logic [smet_pkg::COUNT_W-1:0]  entry_total;
   } table_answer_type;

   logic                             clock            = 1'b0;
   logic                             reset            = 1'b1;
   logic                             req_valid        = 1'b0;
   logic                             req_stall;
   logic [smet_pkg::KIND_W-1:0]      req_kind         = '0;
   logic [smet_pkg::INDEX_W-1:0]     req_row_index    = '0;
   logic [smet_pkg::INDEX_W-1:0]     req_column_index = '0;
   logic [smet_pkg::VALUE_W-1:0]     req_entry_value  = '0;
   logic                             rsp_valid;
   logic                             rsp_stall        = 1'b0;
   logic [smet_pkg::STATUS_W-1:0]    rsp_status;
   logic [smet_pkg::VALUE_W-1:0]     rsp_read_value;
   logic [smet_pkg::COUNT_W-1:0]     rsp_entry_total;
   logic                             csr_valid        = 1'b0;
   logic                             csr_ready;
   logic [smet_pkg::CSR_INDEX_W-1:0] csr_index        = '0;
   logic [smet_pkg::DIM_W-1:0]       csr_data         = '0;

   // request queue, predictions awaiting a response, run status
   table_request_type pending_requests[$];
   table_answer_type  awaited_results[$];
   table_request_type offered_request;
   int                error_count        = 0;
   int                cycle_count        = 0;
   int                sender_idle_pct    = 0;
   int                receiver_stall_pct = 0;

   // shadow coordinate table and limits
   logic [smet_pkg::INDEX_W-1:0] shadow_rows[smet_pkg::CAPACITY];
   logic [smet_pkg::INDEX_W-1:0] shadow_columns[smet_pkg::CAPACITY];
   logic [smet_pkg::VALUE_W-1:0] shadow_values[smet_pkg::CAPACITY];
   int                           shadow_count        = 0;
   logic [smet_pkg::DIM_W-1:0]   shadow_row_limit    = smet_pkg::DIM_RESET;
   logic [smet_pkg::DIM_W-1:0]   shadow_column_limit = smet_pkg::DIM_RESET;

   sparse_matrix_entry_table_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_row_index    (req_row_index),
      .req_column_index (req_column_index),
      .req_entry_value  (req_entry_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_read_value   (rsp_read_value),
      .rsp_entry_total  (rsp_entry_total),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #10 clock = ~clock;

   // apply one request to the shadow table and return the response it earns
   function automatic table_answer_type apply_table_op(input table_request_type rq);
      table_answer_type ans;
      int               slot;
      logic             fits;
      ans.status     = smet_pkg::STATUS_OK;
      ans.read_value = '0;
      fits = ({1'b0, rq.row} < shadow_row_limit) &&
             ({1'b0, rq.column} < shadow_column_limit);
      slot = -1;
      for (int i = 0; i < shadow_count; i++) begin
         if (slot < 0 && shadow_rows[i] == rq.row && shadow_columns[i] == rq.column) begin
            slot = i;
         end
      end
      case (rq.kind)
         smet_pkg::KIND_INSERT: begin
            if (!fits) begin
               ans.status = smet_pkg::STATUS_BOUNDS;
            end else if (slot >= 0) begin
               shadow_values[slot] = rq.value;
            end else if (shadow_count >= smet_pkg::CAPACITY) begin
               ans.status = smet_pkg::STATUS_FULL;
            end else begin
               shadow_rows[shadow_count]    = rq.row;
               shadow_columns[shadow_count] = rq.column;
               shadow_values[shadow_count]  = rq.value;
               shadow_count++;
            end
         end
         smet_pkg::KIND_REMOVE: begin
            // no bounds check; the last record fills the hole
            if (slot >= 0) begin
               shadow_rows[slot]    = shadow_rows[shadow_count-1];
               shadow_columns[slot] = shadow_columns[shadow_count-1];
               shadow_values[slot]  = shadow_values[shadow_count-1];
               shadow_count--;
            end else begin
               ans.status = smet_pkg::STATUS_MISSING;
            end
         end
         smet_pkg::KIND_READ: begin
            if (!fits) begin
               ans.status = smet_pkg::STATUS_BOUNDS;
            end else if (slot >= 0) begin
               ans.read_value = shadow_values[slot];
            end
         end
         default: begin
         end
      endcase
      ans.entry_total = shadow_count[smet_pkg::COUNT_W-1:0];
      return ans;
   endfunction

   // request driver: predict on acceptance, hold a stalled request
   always @(posedge clock) begin
      logic load;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_results.push_back(apply_table_op(offered_request));
         end
         if (!req_valid || !req_stall) begin
            load = pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct;
            if (load) begin
               offered_request  = pending_requests.pop_front();
               req_valid        <= 1'b1;
               req_kind         <= offered_request.kind;
               req_row_index    <= offered_request.row;
               req_column_index <= offered_request.column;
               req_entry_value  <= offered_request.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: compare against the oldest prediction, stall at random
   always @(posedge clock) begin
      table_answer_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_read_value !== want.read_value) begin
                  $error("read_value: expected %h, got %h", want.read_value, rsp_read_value);
                  error_count++;
               end
               if (rsp_entry_total !== want.entry_total) begin
                  $error("entry_total: expected %0d, got %0d", want.entry_total,
                         rsp_entry_total);
                  error_count++;
               end
            end
         end
         rsp_stall <= $urandom_range(99) < receiver_stall_pct;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic queue_op(input logic [smet_pkg::KIND_W-1:0] kind,
                           input logic [smet_pkg::INDEX_W-1:0] row,
                           input logic [smet_pkg::INDEX_W-1:0] column,
                           input logic [smet_pkg::VALUE_W-1:0] value);
      table_request_type rq;
      rq.kind   = kind;
      rq.row    = row;
      rq.column = column;
      rq.value  = value;
      pending_requests.push_back(rq);
   endtask

   // wait until every request has gone in and every response has come back
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || awaited_results.size() != 0);
   endtask

   task automatic write_register(input logic [smet_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [smet_pkg::DIM_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == smet_pkg::CSR_ROW_COUNT) begin
         shadow_row_limit = data;
      end else if (idx == smet_pkg::CSR_COLUMN_COUNT) begin
         shadow_column_limit = data;
      end
   endtask

   task automatic set_limits(input logic [smet_pkg::DIM_W-1:0] rows,
                             input logic [smet_pkg::DIM_W-1:0] columns);
      wait_drained();
      write_register(smet_pkg::CSR_ROW_COUNT, rows);
      write_register(smet_pkg::CSR_COLUMN_COUNT, columns);
   endtask

   // mostly a small pool so records collide, sometimes near the limit or wide
   function automatic logic [smet_pkg::INDEX_W-1:0] pick_index(
      input logic [smet_pkg::DIM_W-1:0] limit, input int span);
      int                           pick;
      logic [smet_pkg::INDEX_W-1:0] edge_index;
      pick = $urandom_range(99);
      edge_index = (limit > smet_pkg::DIM_RESET) ? '1 : limit[smet_pkg::INDEX_W-1:0];
      if (pick < 60) return smet_pkg::INDEX_W'($urandom_range(span));
      if (pick < 75) return (limit == '0) ? '0 :
                            edge_index - ((limit > smet_pkg::DIM_RESET) ? 16'd0 : 16'd1);
      if (pick < 85) return (limit >= smet_pkg::DIM_RESET) ? '1 : edge_index;
      if (pick < 95) return smet_pkg::INDEX_W'($urandom);
      return ($urandom_range(1) == 1) ? '1 : '0;
   endfunction

   function automatic logic [smet_pkg::VALUE_W-1:0] random_value();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   // stimulus sequence
   initial begin
      logic [smet_pkg::DIM_W-1:0]  row_limits[PHASE_COUNT];
      logic [smet_pkg::DIM_W-1:0]  column_limits[PHASE_COUNT];
      logic [smet_pkg::KIND_W-1:0] kind;
      int                          made;
      int                          pick;
      row_limits    = '{17'h10000, 17'd8,  17'd1, 17'h1FFFF, 17'hFFFF, 17'd4,  17'd0, 17'h10000};
      column_limits = '{17'h10000, 17'd12, 17'd1, 17'h10000, 17'd3,    17'd16, 17'd0, 17'h10000};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, every operation, update, hole fill on remove
      queue_op(smet_pkg::KIND_READ, 16'd0, 16'd0, '1);
      queue_op(smet_pkg::KIND_REMOVE, 16'd0, 16'd0, '0);
      queue_op(KIND_UNUSED, 16'hFFFF, 16'hFFFF, '1);
      queue_op(smet_pkg::KIND_INSERT, 16'd0, 16'd0, '1);
      queue_op(smet_pkg::KIND_INSERT, 16'hFFFF, 16'hFFFF, '0);
      queue_op(smet_pkg::KIND_INSERT, 16'd0, 16'hFFFF, 64'h8000_0000_0000_0001);
      queue_op(smet_pkg::KIND_READ, 16'hFFFF, 16'hFFFF, '0);
      queue_op(smet_pkg::KIND_INSERT, 16'd0, 16'd0, 64'h0123_4567_89AB_CDEF);
      queue_op(smet_pkg::KIND_READ, 16'd0, 16'd0, '0);
      queue_op(smet_pkg::KIND_REMOVE, 16'd0, 16'd0, '0);
      queue_op(smet_pkg::KIND_READ, 16'd0, 16'hFFFF, '0);
      queue_op(smet_pkg::KIND_READ, 16'd0, 16'd0, '0);

      // directed: bounds on insert and read, none on remove
      set_limits(17'd2, 17'd3);
      queue_op(smet_pkg::KIND_INSERT, 16'd1, 16'd2, 64'hFEDC_BA98_7654_3210);
      queue_op(smet_pkg::KIND_INSERT, 16'd2, 16'd0, '1);
      queue_op(smet_pkg::KIND_READ, 16'd0, 16'd3, '0);
      queue_op(smet_pkg::KIND_REMOVE, 16'hFFFF, 16'hFFFF, '0);
      queue_op(smet_pkg::KIND_REMOVE, 16'hFFFF, 16'd0, '0);

      // directed: zero in either limit rejects every insert and read
      set_limits(17'd0, 17'h10000);
      queue_op(smet_pkg::KIND_INSERT, 16'd0, 16'd0, '1);
      queue_op(smet_pkg::KIND_READ, 16'd1, 16'd2, '0);
      set_limits(17'h10000, 17'd0);
      queue_op(smet_pkg::KIND_INSERT, 16'd0, 16'd0, '1);

      // directed: limits above the index range pass every index
      set_limits(17'h1FFFF, 17'h10001);
      queue_op(smet_pkg::KIND_INSERT, 16'hFFFF, 16'hFFFF, 64'hA5A5_5A5A_A5A5_5A5A);
      queue_op(smet_pkg::KIND_READ, 16'hFFFF, 16'hFFFF, '0);
      queue_op(KIND_UNUSED, 16'd0, 16'd0, '0);

      // random phases, each with its own limits and idling mode
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         set_limits(row_limits[phase], column_limits[phase]);
         if (phase == 2) begin
            write_register(CSR_UNMAPPED_A, smet_pkg::DIM_W'($urandom));
            write_register(CSR_UNMAPPED_B, '1);
         end
         case (phase % 4)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 70;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 70;
            end
            default: begin
               sender_idle_pct = 13;
               receiver_stall_pct = 13;
            end
         endcase
         made = 0;
         while (made < ITEMS_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
               // fill burst: enough fresh positions to reach a full table
               repeat (70) begin
                  queue_op(smet_pkg::KIND_INSERT, smet_pkg::INDEX_W'($urandom_range(7)),
                           smet_pkg::INDEX_W'($urandom_range(15)), random_value());
               end
               made += 70;
            end else if (pick < 14) begin
               // clear burst: empty most of the pool again
               repeat (40) begin
                  queue_op(smet_pkg::KIND_REMOVE, smet_pkg::INDEX_W'($urandom_range(7)),
                           smet_pkg::INDEX_W'($urandom_range(15)), random_value());
               end
               made += 40;
            end else begin
               pick = $urandom_range(99);
               kind = (pick < 45) ? smet_pkg::KIND_INSERT :
                      (pick < 60) ? smet_pkg::KIND_REMOVE :
                      (pick < 94) ? smet_pkg::KIND_READ : KIND_UNUSED;
               queue_op(kind, pick_index(shadow_row_limit, 7),
                        pick_index(shadow_column_limit, 15), random_value());
               made++;
            end
         end
      end

      // let the last responses settle, then report
      wait_drained();
      repeat (100) @(posedge clock);
      if (error_count == 0 && awaited_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: sparse_matrix_entry_table_core.f
rtl/smet_pkg.sv
rtl/smet_ram.sv
rtl/sparse_matrix_entry_table_core.sv
dv/testbench.sv
